// ===== design/bds_pkg.sv =====
package bds_pkg;

    localparam int MAX_OUT_WIDTH = 512;
    localparam int MAX_OUT_HEIGHT = 512;
    localparam int MAX_ROW_LEN = 4096;
    localparam int LAST_ROW = 2047;
    localparam int NUM_CH = 4;

    localparam int BCOL_W = $clog2(MAX_OUT_WIDTH);
    localparam int SUM_W = 12;
    localparam int HSUM_W = 10;

    typedef enum logic [1:0] {
        CFG_OUT_WIDTH    = 2'd0,
        CFG_OUT_HEIGHT   = 2'd1,
        CFG_SOURCE_WIDTH = 2'd2,
        CFG_NONE         = 2'd3
    } cfg_reg_t;

    typedef logic [NUM_CH-1:0][7:0] pixel_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

    // per-item control passed to the column sum unit
    typedef struct packed {
        logic              take;
        logic              grp_first;
        logic              grp_last;
        logic              row_first;
        logic [BCOL_W-1:0] bcol;
    } pix_ctl_t;

endpackage

// ===== design/box_downsample_4x4.sv =====
// channel  | signals                                              | flow
// ---------+------------------------------------------------------+---------------------
// pixel    | pix_valid, pix_stall, byte_0..3, frame_start         | in, stall from block
// result   | res_valid, res_stall, out_col, out_row, avg_0..3,    | out, stall from sink
//          | frame_last                                           |
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data            | in, always ready
//
// one pixel per clock while pix_stall is low; a result is registered from the last pixel of its block
// the column sum memory is read once and written once per four pixels of a block row
// reset clears the counters, the config registers and res_valid; the sum memory needs no clearing
// pix_stall is high only while a result is held and res_stall is high
module box_downsample_4x4 import bds_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,

    input  logic        pix_valid,
    output logic        pix_stall,
    input  logic [7:0]  byte_0,
    input  logic [7:0]  byte_1,
    input  logic [7:0]  byte_2,
    input  logic [7:0]  byte_3,
    input  logic        frame_start,

    output logic        res_valid,
    input  logic        res_stall,
    output logic [8:0]  out_col,
    output logic [8:0]  out_row,
    output logic [7:0]  avg_0,
    output logic [7:0]  avg_1,
    output logic [7:0]  avg_2,
    output logic [7:0]  avg_3,
    output logic        frame_last
);

    logic [9:0]  out_width_reg;
    logic [9:0]  out_height_reg;
    logic [12:0] source_width_reg;

    logic [11:0] source_col_reg;
    logic [11:0] source_col_next;
    logic [10:0] source_row_reg;
    logic [10:0] source_row_next;
    logic        past_end_reg;
    logic        past_end_next;

    logic        res_valid_reg;
    logic [8:0]  out_col_reg;
    logic [8:0]  out_row_reg;
    pixel_t      avg_reg;
    logic        frame_last_reg;

    logic [9:0]  eff_w;
    logic [9:0]  eff_h;
    logic [11:0] span_w;
    logic [11:0] span_h;
    logic [12:0] row_len;
    logic [11:0] col;
    logic [10:0] row;
    logic        pe;
    logic        in_range;
    logic        accept;
    logic        produce;
    logic [9:0]  bcol;
    logic [8:0]  orow;
    pix_ctl_t    ctl;
    pixel_t      pix;
    sums_t       total;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg    <= 10'd1;
            out_height_reg   <= 10'd1;
            source_width_reg <= 13'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_OUT_WIDTH:    out_width_reg    <= cfg_data[9:0];
                CFG_OUT_HEIGHT:   out_height_reg   <= cfg_data[9:0];
                CFG_SOURCE_WIDTH: source_width_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp the geometry to what the counters and memory cover
    always_comb
    begin
        if (out_width_reg == '0)
            eff_w = 10'd1;
        else if (out_width_reg > 10'(MAX_OUT_WIDTH))
            eff_w = 10'(MAX_OUT_WIDTH);
        else
            eff_w = out_width_reg;

        if (out_height_reg == '0)
            eff_h = 10'd1;
        else if (out_height_reg > 10'(MAX_OUT_HEIGHT))
            eff_h = 10'(MAX_OUT_HEIGHT);
        else
            eff_h = out_height_reg;

        span_w = {eff_w, 2'b00};
        span_h = {eff_h, 2'b00};

        if (source_width_reg < {1'b0, span_w})
            row_len = {1'b0, span_w};
        else if (source_width_reg > 13'(MAX_ROW_LEN))
            row_len = 13'(MAX_ROW_LEN);
        else
            row_len = source_width_reg;
    end

    assign pix_stall = res_valid_reg && res_stall;
    assign accept    = pix_valid && !pix_stall;

    assign col = frame_start ? '0 : source_col_reg;
    assign row = frame_start ? '0 : source_row_reg;
    assign pe  = frame_start ? 1'b0 : past_end_reg;

    assign in_range = !pe && (col < span_w) && ({1'b0, row} < span_h);
    assign bcol     = col[11:2];
    assign orow     = row[10:2];
    assign produce  = in_range && (col[1:0] == 2'b11) && (row[1:0] == 2'b11);

    always_comb
    begin
        source_col_next = col;
        source_row_next = row;
        past_end_next   = pe;
        if (!pe)
        begin
            if ({1'b0, col} + 13'd1 >= row_len)
            begin
                source_col_next = '0;
                if (row >= 11'(LAST_ROW))
                    past_end_next = 1'b1;
                else
                    source_row_next = row + 11'd1;
            end
            else
            begin
                source_col_next = col + 12'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_col_reg <= '0;
            source_row_reg <= '0;
            past_end_reg   <= 1'b0;
        end
        else if (accept)
        begin
            source_col_reg <= source_col_next;
            source_row_reg <= source_row_next;
            past_end_reg   <= past_end_next;
        end
    end

    assign pix = {byte_3, byte_2, byte_1, byte_0};

    always_comb
    begin
        ctl.take      = accept && in_range;
        ctl.grp_first = (col[1:0] == 2'b00);
        ctl.grp_last  = (col[1:0] == 2'b11);
        ctl.row_first = (row[1:0] == 2'b00);
        ctl.bcol      = bcol[BCOL_W-1:0];
    end

    bds_colsum u_colsum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pix   (pix),
        .total (total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept && produce)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            out_col_reg    <= bcol[8:0];
            out_row_reg    <= orow;
            frame_last_reg <= (bcol == eff_w - 10'd1) && ({1'b0, orow} == eff_h - 10'd1);
            for (int ch = 0; ch < NUM_CH; ch++)
                avg_reg[ch] <= total[ch][SUM_W-1:4];
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign avg_0      = avg_reg[0];
    assign avg_1      = avg_reg[1];
    assign avg_2      = avg_reg[2];
    assign avg_3      = avg_reg[3];
    assign frame_last = frame_last_reg;

endmodule

// ===== design/bds_colsum.sv =====
module bds_colsum import bds_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  pix_ctl_t ctl,
    input  pixel_t   pix,
    output sums_t    total
);

    logic [NUM_CH*SUM_W-1:0] mem [MAX_OUT_WIDTH];

    logic [NUM_CH*SUM_W-1:0]            rd_reg;
    logic [NUM_CH-1:0][HSUM_W-1:0]      hsum_reg;
    logic [NUM_CH-1:0][HSUM_W-1:0]      hsum_next;
    sums_t                              prev;

    // horizontal run over the four pixels of one block row
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (ctl.grp_first)
                hsum_next[ch] = {{(HSUM_W-8){1'b0}}, pix[ch]};
            else
                hsum_next[ch] = hsum_reg[ch] + {{(HSUM_W-8){1'b0}}, pix[ch]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsum_reg <= '0;
        end
        else if (ctl.take)
        begin
            hsum_reg <= hsum_next;
        end
    end

    // column entry is fetched at the group start, used and rewritten at its end
    always_ff @(posedge clk)
    begin
        if (ctl.take && ctl.grp_first)
            rd_reg <= mem[ctl.bcol];
        if (ctl.take && ctl.grp_last)
            mem[ctl.bcol] <= total;
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            prev[ch] = ctl.row_first ? '0 : rd_reg[ch*SUM_W +: SUM_W];
            total[ch] = prev[ch] + {{(SUM_W-HSUM_W){1'b0}}, hsum_next[ch]};
        end
    end

endmodule
